[design/shift_and_bit_op_unit_macros.svh]
// Assertion macros for the shift and bit-operation unit.
// Relies on clk and arst_n being visible in the module that expands them.

`ifndef SHIFT_AND_BIT_OP_UNIT_MACROS_SVH
`define SHIFT_AND_BIT_OP_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every clock edge outside reset.
`define SBOU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbou: check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define SBOU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbou: check failed");

`else

`define SBOU_ASSERT_IMPL(lbl, ante, cons)
`define SBOU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/sbou_pkg.sv]
// Types and constants of the shift and bit-operation unit.
// No dependencies; imported by shift_and_bit_op_unit.

package sbou_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned OP_W      = 4;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned AMOUNT_W  = 5;
	localparam int unsigned SETTING_W = 7;
	// Select bit of entry 0 in a write beat; entry i uses bit SEL_LSB + i.
	localparam int unsigned SEL_LSB   = 8;

	typedef enum logic [1:0] {
		MODE_ROTL = 2'd0,
		MODE_SHL  = 2'd1,
		MODE_SHRZ = 2'd2,
		MODE_SHRS = 2'd3
	} shift_mode_t;

	typedef struct packed {
		shift_mode_t           mode;
		logic [AMOUNT_W-1:0]   amount;
	} shift_setting_t;

	localparam logic KIND_TRANSFORM = 1'b0;
	localparam logic KIND_WRITE     = 1'b1;

	localparam logic [OP_W-1:0] OP_SHIFT_LO = 4'd0;
	localparam logic [OP_W-1:0] OP_SHIFT_HI = 4'd7;
	localparam logic [OP_W-1:0] OP_INVERT   = 4'd8;
	localparam logic [OP_W-1:0] OP_REVERSE  = 4'd13;
	localparam logic [OP_W-1:0] OP_SET      = 4'd14;
	localparam logic [OP_W-1:0] OP_CLEAR    = 4'd15;

	localparam logic [AMOUNT_W:0] FULL_SHIFT = 6'd32;

endpackage

[design/shift_and_bit_op_unit.sv]
// Shift and bit-operation unit: top level, shift-setting table and datapath.
// Depends on sbou_pkg and shift_and_bit_op_unit_macros.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | kind, op, data, bit_mask, bit_pos
//   out     | out_valid / out_ready| result, bit_is_set, bit_is_clear,
//           |                      | masked_zero, masked_nonzero,
//           |                      | result_zero, result_nonzero
//
// One beat per cycle sustained while out_ready is high. A transform beat sits in _s1
// after its accepting edge and moves to _s2 once _s2 is free, which raises
// out_valid; the output beat leaves when out_ready is high.
// A write beat updates the table when it leaves _s1 and yields no output beat.
// arst_n clears the valid bits and all shift-setting entries.
// When out_ready is low and _s2 is full, _s1 holds a transform beat and
// in_ready drops only once _s1 is also blocked.

`include "shift_and_bit_op_unit_macros.svh"

module shift_and_bit_op_unit #(
	parameter int unsigned SHIFT_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [3:0]  op,
	input  logic [31:0] data,
	input  logic [31:0] bit_mask,
	input  logic [4:0]  bit_pos,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result,
	output logic        bit_is_set,
	output logic        bit_is_clear,
	output logic        masked_zero,
	output logic        masked_nonzero,
	output logic        result_zero,
	output logic        result_nonzero
);

	import sbou_pkg::*;

	// ---------------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------------
	logic              valid_s1;
	logic              kind_s1;
	logic [OP_W-1:0]   op_s1;
	logic [DATA_W-1:0] data_s1;
	logic [DATA_W-1:0] mask_s1;
	logic [POS_W-1:0]  pos_s1;

	logic              valid_s2;
	logic              s2_free;
	logic              s2_load;
	logic              s1_done;
	logic              in_take;

	// A write beat never needs the result stage, so it retires from _s1 at once.
	assign s2_free  = !valid_s2 || out_ready;
	assign s2_load  = valid_s1 && (kind_s1 == KIND_TRANSFORM) && s2_free;
	assign s1_done  = valid_s1 && ((kind_s1 == KIND_WRITE) || s2_free);
	assign in_ready = !valid_s1 || s1_done;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= kind;
			op_s1   <= op;
			data_s1 <= data;
			mask_s1 <= bit_mask;
			pos_s1  <= bit_pos;
		end
	end

	// ---------------------------------------------------------------------
	// Shift-setting table: one register per entry, loaded by select bit
	// ---------------------------------------------------------------------
	shift_setting_t settings_q [SHIFT_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SHIFT_ENTRIES; i++) begin
				settings_q[i] <= '0;
			end
		end else if (valid_s1 && (kind_s1 == KIND_WRITE)) begin
			for (int i = 0; i < SHIFT_ENTRIES; i++) begin
				if (data_s1[SEL_LSB + i]) begin
					settings_q[i] <= shift_setting_t'(data_s1[SETTING_W-1:0]);
				end
			end
		end
	end

	// Pick the entry named by the op; an op past the last entry reads as zero,
	// which is a rotate by zero and so passes the data.
	shift_setting_t setting;

	always_comb begin
		setting = '0;
		for (int i = 0; i < SHIFT_ENTRIES; i++) begin
			if (op_s1[2:0] == 3'(i)) begin
				setting = settings_q[i];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Barrel shifter
	// ---------------------------------------------------------------------
	logic [AMOUNT_W:0]   right_amt;
	logic [2*DATA_W-1:0] rot_wide;
	logic [DATA_W-1:0]   shifted;

	// Right shifts go by 32 minus the amount; amount zero means a full 32.
	assign right_amt = FULL_SHIFT - {1'b0, setting.amount};
	// Rotate left by s is the low word of {d,d} >> (32 - s); s of zero
	// lands on a shift by 32 and returns the data.
	assign rot_wide  = {data_s1, data_s1} >> right_amt;

	always_comb begin
		case (setting.mode)
			MODE_ROTL: shifted = rot_wide[DATA_W-1:0];
			MODE_SHL:  shifted = data_s1 << setting.amount;
			MODE_SHRZ: shifted = data_s1 >> right_amt;
			MODE_SHRS: shifted = DATA_W'($signed(data_s1) >>> right_amt);
			default:   shifted = data_s1;
		endcase
	end

	// ---------------------------------------------------------------------
	// Operation select and flags
	// ---------------------------------------------------------------------
	logic [DATA_W-1:0] reversed;
	logic [DATA_W-1:0] pos_bit;
	logic [DATA_W-1:0] res_next;
	logic              masked_any;

	always_comb begin
		for (int i = 0; i < DATA_W; i++) begin
			reversed[i] = data_s1[DATA_W-1-i];
		end
	end

	assign pos_bit = DATA_W'(1) << pos_s1;

	always_comb begin
		case (op_s1) inside
			[OP_SHIFT_LO:OP_SHIFT_HI]: res_next = shifted;
			OP_INVERT:                 res_next = ~data_s1;
			OP_REVERSE:                res_next = reversed;
			OP_SET:                    res_next = data_s1 | pos_bit;
			OP_CLEAR:                  res_next = data_s1 & ~pos_bit;
			default:                   res_next = data_s1;
		endcase
	end

	assign masked_any = |(res_next & mask_s1);

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	logic [DATA_W-1:0] result_s2;
	logic              bit_set_s2;
	logic              bit_clear_s2;
	logic              mask_zero_s2;
	logic              mask_nonzero_s2;
	logic              res_zero_s2;
	logic              res_nonzero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s2_load;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			result_s2       <= res_next;
			bit_set_s2      <= res_next[pos_s1];
			bit_clear_s2    <= !res_next[pos_s1];
			mask_zero_s2    <= !masked_any;
			mask_nonzero_s2 <= masked_any;
			res_zero_s2     <= (res_next == '0);
			res_nonzero_s2  <= (res_next != '0);
		end
	end

	assign out_valid      = valid_s2;
	assign result         = result_s2;
	assign bit_is_set     = bit_set_s2;
	assign bit_is_clear   = bit_clear_s2;
	assign masked_zero    = mask_zero_s2;
	assign masked_nonzero = mask_nonzero_s2;
	assign result_zero    = res_zero_s2;
	assign result_nonzero = res_nonzero_s2;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`SBOU_ASSERT_IMPL(a_zero_flag, valid_s2, res_zero_s2 == (result_s2 == '0))
	`SBOU_ASSERT_IMPL(a_mask_flags, valid_s2, mask_zero_s2 != mask_nonzero_s2)
	`SBOU_ASSERT_NEXT(a_hold_s1, valid_s1 && (kind_s1 == KIND_TRANSFORM) && valid_s2 && !out_ready, valid_s1)

endmodule

[verif/tb_shift_and_bit_op_unit.sv]
// Self-checking testbench for shift_and_bit_op_unit: directed and random beats with checking.
// Depends on sbou_pkg and the shift_and_bit_op_unit RTL only; reads no files.
// Tracks the shift-setting table alongside the block and predicts every output beat.

module tb_shift_and_bit_op_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sbou_pkg::*;

	localparam int unsigned N_ENTRIES    = 8;
	localparam int unsigned RANDOM_BEATS = 825;
	// The block is two stages deep, so a short drain window is plenty.
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned TIMEOUT_NS   = 2_000_000;

	// Ops 9 to 12 have no package names; they pass the data through.
	localparam logic [OP_W-1:0] OP_PASS_FIRST = 4'd9;
	localparam logic [OP_W-1:0] OP_PASS_LAST  = 4'd12;

	typedef struct {
		logic              kind;
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] bit_mask;
		logic [POS_W-1:0]  bit_pos;
	} beat_t;

	typedef struct {
		logic [DATA_W-1:0] word;
		logic              bit_set;
		logic              bit_clear;
		logic              mask_zero;
		logic              mask_nonzero;
		logic              word_zero;
		logic              word_nonzero;
	} outcome_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic              kind           = KIND_TRANSFORM;
	logic [OP_W-1:0]   op             = OP_SHIFT_LO;
	logic [DATA_W-1:0] data           = '0;
	logic [DATA_W-1:0] bit_mask       = '0;
	logic [POS_W-1:0]  bit_pos        = '0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic [DATA_W-1:0] result;
	logic              bit_is_set;
	logic              bit_is_clear;
	logic              masked_zero;
	logic              masked_nonzero;
	logic              result_zero;
	logic              result_nonzero;

	beat_t          pending_beats[$];
	outcome_t       awaited_results[$];
	shift_setting_t shift_table[N_ENTRIES];
	int             errors    = 0;
	int unsigned    cycle_cnt = 0;
	int             tx_gap    = 0;
	int             rx_wait   = 0;
	logic           rx_hold;

	shift_and_bit_op_unit #(
		.SHIFT_ENTRIES(N_ENTRIES)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.op            (op),
		.data          (data),
		.bit_mask      (bit_mask),
		.bit_pos       (bit_pos),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result        (result),
		.bit_is_set    (bit_is_set),
		.bit_is_clear  (bit_is_clear),
		.masked_zero   (masked_zero),
		.masked_nonzero(masked_nonzero),
		.result_zero   (result_zero),
		.result_nonzero(result_nonzero)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Free-running cycle count; drives the calm stretches and the long receiver hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			cycle_cnt <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
		end
	end

	// Hold off the receiver for long windows so the pipeline fills and drops in_ready.
	assign rx_hold = (cycle_cnt >= 300 && cycle_cnt < 380) ||
		(cycle_cnt >= 2500 && cycle_cnt < 2560);

	// Draw a random per-beat wait, except in calm stretches with no idling at all.
	function automatic int idle_cycles();
		if ((cycle_cnt / 300) % 4 == 1)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	// Shift by one table entry, mode and amount as stored.
	// Right shifts go by 32 minus the amount, so an amount of zero means a full 32-bit shift.
	function automatic logic [DATA_W-1:0] shifted_word(shift_setting_t st, logic [DATA_W-1:0] d);
		logic [AMOUNT_W:0]   rs;
		logic [2*DATA_W-1:0] wide;
		logic [DATA_W-1:0]   r;
		rs = FULL_SHIFT - {1'b0, st.amount};
		case (st.mode)
		MODE_ROTL: begin
			// d >> 32 is zero, so a rotate by zero returns d
			r = (d << st.amount) | (d >> rs);
		end
		MODE_SHL: begin
			r = d << st.amount;
		end
		MODE_SHRZ: begin
			r = d >> rs;
		end
		default: begin
			wide = {{DATA_W{d[DATA_W-1]}}, d} >> rs;
			r = wide[DATA_W-1:0];
		end
		endcase
		return r;
	endfunction

	// Advance the table on a write beat, or queue the outcome of a transform beat.
	task automatic track_beat(input beat_t b);
		shift_setting_t    st;
		logic [DATA_W-1:0] r;
		outcome_t          o;
		if (b.kind == KIND_WRITE) begin
			for (int i = 0; i < N_ENTRIES; i++)
				if (b.data[SEL_LSB + i])
					shift_table[i] = shift_setting_t'(b.data[SETTING_W-1:0]);
		end else begin
			if (b.op <= OP_SHIFT_HI) begin
				// An entry that does not exist reads as zero: rotate by zero
				st = '0;
				if (b.op < N_ENTRIES)
					st = shift_table[b.op];
				r = shifted_word(st, b.data);
			end else if (b.op == OP_INVERT) begin
				r = ~b.data;
			end else if (b.op == OP_REVERSE) begin
				for (int i = 0; i < DATA_W; i++)
					r[i] = b.data[DATA_W-1-i];
			end else if (b.op == OP_SET) begin
				r = b.data | (32'd1 << b.bit_pos);
			end else if (b.op == OP_CLEAR) begin
				r = b.data & ~(32'd1 << b.bit_pos);
			end else begin
				r = b.data;
			end
			o.word         = r;
			o.bit_set      = r[b.bit_pos];
			o.bit_clear    = !r[b.bit_pos];
			o.mask_zero    = (r & b.bit_mask) == '0;
			o.mask_nonzero = (r & b.bit_mask) != '0;
			o.word_zero    = r == '0;
			o.word_nonzero = r != '0;
			awaited_results.push_back(o);
		end
	endtask

	task automatic add_beat(input logic k, input logic [OP_W-1:0] o, input logic [DATA_W-1:0] d,
		input logic [DATA_W-1:0] m, input logic [POS_W-1:0] p);
		beat_t b;
		b.kind     = k;
		b.op       = o;
		b.data     = d;
		b.bit_mask = m;
		b.bit_pos  = p;
		pending_beats.push_back(b);
	endtask

	task automatic check_field(input string what, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
			errors++;
		end
	endtask

	// Driver: offer the head of pending_beats; hold valid and payload until the beat is taken.
	// Predict at acceptance so table writes and transforms are seen in the block's order.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
			foreach (shift_table[i])
				shift_table[i] = '0;
		end else begin
			if (in_valid && in_ready) begin
				track_beat(pending_beats.pop_front());
				tx_gap = idle_cycles();
			end else if (!in_valid && tx_gap > 0) begin
				tx_gap--;
			end
			// Leave a beat that is still waiting for ready alone
			if (!in_valid || in_ready) begin
				if (tx_gap == 0 && pending_beats.size() > 0) begin
					kind     <= pending_beats[0].kind;
					op       <= pending_beats[0].op;
					data     <= pending_beats[0].data;
					bit_mask <= pending_beats[0].bit_mask;
					bit_pos  <= pending_beats[0].bit_pos;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted output beat against the oldest outcome, then stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t ns: output beat with no outcome pending, got result %h",
						$time, result);
					errors++;
				end else begin
					outcome_t want;
					want = awaited_results.pop_front();
					check_field("result", want.word, result);
					check_field("bit_is_set", DATA_W'(want.bit_set), DATA_W'(bit_is_set));
					check_field("bit_is_clear", DATA_W'(want.bit_clear),
						DATA_W'(bit_is_clear));
					check_field("masked_zero", DATA_W'(want.mask_zero),
						DATA_W'(masked_zero));
					check_field("masked_nonzero", DATA_W'(want.mask_nonzero),
						DATA_W'(masked_nonzero));
					check_field("result_zero", DATA_W'(want.word_zero),
						DATA_W'(result_zero));
					check_field("result_nonzero", DATA_W'(want.word_nonzero),
						DATA_W'(result_nonzero));
				end
				rx_wait = idle_cycles();
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0) && !rx_hold;
		end
	end

	initial begin
		int                n;
		int                pick;
		logic [OP_W-1:0]   o;
		logic [DATA_W-1:0] w;
		logic [DATA_W-1:0] m;
		logic [POS_W-1:0]  p;

		// Directed: the table starts at zero, so shift ops first rotate by zero
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO, 32'h8000_0001, 32'hffff_ffff, 5'd0);
		// Load every entry with left shift by zero; bit 7 of the value must be dropped
		add_beat(KIND_WRITE, OP_CLEAR, {16'h5a5a, 8'hff, 8'ha0}, 32'hffff_ffff, 5'd31);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO + 4'd3, 32'hffff_ffff, 32'h0000_0000, 5'd31);
		// Right shift with amount zero: a full shift, zero fill gives 0
		add_beat(KIND_WRITE, OP_SHIFT_LO, {16'ha5a5, 8'h01, 8'h40}, 32'h0, 5'd0);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO, 32'hdead_beef, 32'hffff_ffff, 5'd4);
		// Sign fill with amount zero, both signs
		add_beat(KIND_WRITE, OP_SHIFT_LO, {16'h0000, 8'h02, 8'h60}, 32'h0, 5'd0);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO + 4'd1, 32'h8000_0000, 32'h0000_0001, 5'd31);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO + 4'd1, 32'h7fff_ffff, 32'hffff_ffff, 5'd0);
		// Amount 31 for rotate, left shift and zero-fill right shift; amount 1 for sign fill
		add_beat(KIND_WRITE, OP_SHIFT_LO, {16'hffff, 8'h04, 8'h1f}, 32'h0, 5'd0);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO + 4'd2, 32'h8000_0001, 32'h8000_0000, 5'd30);
		add_beat(KIND_WRITE, OP_SHIFT_LO, {16'h0000, 8'h08, 8'h3f}, 32'h0, 5'd0);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO + 4'd3, 32'hffff_ffff, 32'h7fff_ffff, 5'd31);
		add_beat(KIND_WRITE, OP_SHIFT_LO, {16'h0000, 8'h10, 8'h5f}, 32'h0, 5'd0);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO + 4'd4, 32'hffff_ffff, 32'h8000_0000, 5'd31);
		add_beat(KIND_WRITE, OP_SHIFT_LO, {16'h0000, 8'h20, 8'h61}, 32'h0, 5'd0);
		add_beat(KIND_TRANSFORM, OP_SHIFT_LO + 4'd5, 32'h8000_0000, 32'h0000_0001, 5'd0);
		// Empty select: nothing changes, entry 6 still shifts left by zero
		add_beat(KIND_WRITE, OP_INVERT, {16'hc3c3, 8'h00, 8'h7f}, 32'hffff_ffff, 5'd9);
		add_beat(KIND_TRANSFORM, OP_SHIFT_HI - 4'd1, 32'h1234_5678, 32'h0000_ff00, 5'd3);
		add_beat(KIND_TRANSFORM, OP_INVERT, 32'h0000_0000, 32'h0000_0000, 5'd0);
		add_beat(KIND_TRANSFORM, OP_REVERSE, 32'h0000_0001, 32'h8000_0000, 5'd31);
		add_beat(KIND_TRANSFORM, OP_SET, 32'h0000_0000, 32'h8000_0000, 5'd31);
		add_beat(KIND_TRANSFORM, OP_CLEAR, 32'hffff_ffff, 32'h0000_0001, 5'd0);
		for (int k = OP_PASS_FIRST; k <= OP_PASS_LAST; k++)
			add_beat(KIND_TRANSFORM, k[OP_W-1:0], 32'h0000_0000, 32'hffff_ffff, 5'd16);

		// Random: mostly transforms, with table rewrites mixed in
		for (n = 0; n < RANDOM_BEATS; n++) begin
			pick = $urandom_range(0, 99);
			p = POS_W'($urandom());
			o = OP_W'($urandom());
			if (pick < 15) begin
				w = $urandom();
				case ($urandom_range(0, 3))
				0: w[SEL_LSB +: 8] = 8'h01 << $urandom_range(0, 7);
				1: w[SEL_LSB +: 8] = 8'hff;
				default: ;
				endcase
				// Favor amount zero so the full-shift repairs show up often
				if ($urandom_range(0, 3) == 0)
					w[AMOUNT_W-1:0] = '0;
				add_beat(KIND_WRITE, o, w, $urandom(), p);
			end else begin
				if (pick < 60)
					o = OP_SHIFT_LO + 4'($urandom_range(0, 7));
				case ($urandom_range(0, 7))
				0: w = 32'h0000_0000;
				1: w = 32'hffff_ffff;
				2: w = 32'h8000_0000;
				3: w = 32'h7fff_ffff;
				default: w = $urandom();
				endcase
				case ($urandom_range(0, 5))
				0: m = 32'h0000_0000;
				1: m = 32'hffff_ffff;
				2: m = 32'd1 << $urandom_range(0, 31);
				default: m = $urandom();
				endcase
				add_beat(KIND_TRANSFORM, o, w, m, p);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every beat to be taken and every outcome to come back
		while (pending_beats.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("shift_and_bit_op_unit test passed");
		else
			$display("shift_and_bit_op_unit test failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("shift_and_bit_op_unit test failed");
		$finish;
	end

endmodule
